[rtl/gnd_pkg.sv]
// ----------------------------------------------------------------------------
// gnd_pkg
// Shared constants and elaboration-time functions for the 2D gradient noise
// block, including the generator for the gradient lookup table.
// ----------------------------------------------------------------------------
package gnd_pkg;

  localparam int unsigned CELL_W     = 32;
  localparam int unsigned GRAD_C_W   = 17;
  localparam int unsigned GRAD_W     = 2 * GRAD_C_W;
  localparam int unsigned DOT_W      = 28;
  localparam int unsigned NOISE_W    = 16;
  localparam int unsigned OQ_DEPTH   = 16;
  localparam int unsigned MQ_DEPTH   = 4;
  localparam int unsigned PIPE_STAGES = 11;

  localparam logic [31:0] HASH_MUL_A  = 32'd3284157443;
  localparam logic [31:0] HASH_MUL_B  = 32'd1911520717;
  localparam logic [31:0] HASH_MUL_C  = 32'd2048419325;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  function automatic logic [31:0] rot16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  function automatic logic [63:0] one_minus(input logic [63:0] v);
    return (v < ONE_Q30) ? (ONE_Q30 - v) : 64'd0;
  endfunction

  function automatic logic [63:0] mul30(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  function automatic logic [63:0] to_q15(input logic [63:0] v);
    logic [63:0] r;
    r = (v + (64'd1 << 14)) >> 15;
    return (r > 64'd32768) ? 64'd32768 : r;
  endfunction

  // Unit gradient {gx, gy} for table entry k, evaluated at elaboration only.
  function automatic logic [GRAD_W-1:0] grad_entry(input int unsigned k,
                                                   input int unsigned ab);
    logic [31:0] phase;
    logic [1:0]  quad;
    logic [63:0] r, th, t2, hs, hc;
    logic signed [GRAD_C_W-1:0] sv, cv, gx, gy;
    phase = 32'(k << (32 - ab));
    quad  = phase[31:30];
    r     = {34'd0, phase[29:0]};
    th    = mul30(r, PI_HALF_Q30);
    t2    = mul30(th, th);

    hs = one_minus(t2 / 110);
    hs = one_minus(mul30(t2, hs) / 72);
    hs = one_minus(mul30(t2, hs) / 42);
    hs = one_minus(mul30(t2, hs) / 20);
    hs = one_minus(mul30(t2, hs) / 6);
    hs = mul30(th, hs);

    hc = one_minus(t2 / 132);
    hc = one_minus(mul30(t2, hc) / 90);
    hc = one_minus(mul30(t2, hc) / 56);
    hc = one_minus(mul30(t2, hc) / 30);
    hc = one_minus(mul30(t2, hc) / 12);
    hc = one_minus(mul30(t2, hc) / 2);

    sv = GRAD_C_W'(to_q15(hs));
    cv = GRAD_C_W'(to_q15(hc));
    case (quad)
      QUAD_0: begin
        gx = cv;
        gy = sv;
      end
      QUAD_1: begin
        gx = -sv;
        gy = cv;
      end
      QUAD_2: begin
        gx = -cv;
        gy = -sv;
      end
      default: begin
        gx = sv;
        gy = -cv;
      end
    endcase
    return {gx, gy};
  endfunction

endpackage

[rtl/gnd_fifo.sv]
// ----------------------------------------------------------------------------
// gnd_fifo
// Small show-ahead queue used between the front end, the pipeline and the
// result port.
// ----------------------------------------------------------------------------
module gnd_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

endmodule

[rtl/gnd_front.sv]
// ----------------------------------------------------------------------------
// gnd_front
// Input side: splits each point into lattice cell and cell fraction and
// queues it for the arithmetic pipeline.
// ----------------------------------------------------------------------------
module gnd_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [31:0]            x_coord,
  input  logic signed [31:0]            y_coord,
  output logic                          item_valid,
  input  logic                          item_take,
  output logic [2*32+2*FRAC_BITS-1:0]   item_data
);
  import gnd_pkg::*;

  localparam int unsigned ITEM_W = 2 * CELL_W + 2 * FRAC_BITS;

  logic [CELL_W-1:0]    ix;
  logic [CELL_W-1:0]    iy;
  logic [FRAC_BITS-1:0] tx;
  logic [FRAC_BITS-1:0] ty;
  logic                 empty;

  // The arithmetic shift gives the floor of the coordinate.
  assign ix = CELL_W'(x_coord >>> FRAC_BITS);
  assign iy = CELL_W'(y_coord >>> FRAC_BITS);
  assign tx = x_coord[FRAC_BITS-1:0];
  assign ty = y_coord[FRAC_BITS-1:0];

  gnd_fifo #(
    .WIDTH(ITEM_W),
    .DEPTH(MQ_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_data({ix, iy, tx, ty}),
    .rd_en  (item_take),
    .rd_data(item_data),
    .full   (full),
    .empty  (empty)
  );

  assign item_valid = !empty;

endmodule

[rtl/gnd_back.sv]
// ----------------------------------------------------------------------------
// gnd_back
// Noise pipeline: corner hashing, gradient lookup, dot products, smoothstep
// blending and rounding, followed by the result queue.
// ----------------------------------------------------------------------------
module gnd_back #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned ANGLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_take,
  input  logic [2*32+2*FRAC_BITS-1:0]   item_data,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [15:0]            noise_value
);
  import gnd_pkg::*;

  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned ROM_N  = 1 << ANGLE_BITS;
  localparam int unsigned RES_W  = $clog2(OQ_DEPTH) + 1;
  localparam int unsigned PG_W   = GRAD_C_W + F + 1;
  localparam int unsigned SUM_W  = PG_W + 1;
  localparam int unsigned DIFF_W = DOT_W + 1;
  localparam int unsigned LP_W   = DIFF_W + F + 2;
  localparam logic [F+1:0] THREE = (F+2)'(3) << F;

  // Gradient table, generated at elaboration.
  logic [GRAD_W-1:0] grad_rom [ROM_N];
  for (genvar k = 0; k < ROM_N; k++) begin : g_rom
    assign grad_rom[k] = grad_entry(k, ANGLE_BITS);
  end

  logic [PIPE_STAGES-1:0] vld;
  logic [RES_W-1:0]       reserved;
  logic                   oq_full;
  logic                   res_push;
  logic                   res_pop;
  logic signed [NOISE_W-1:0] res_value;

  // Stage 0: cell corners.
  logic [CELL_W-1:0] s0_ix, s0_ix1, s0_iy, s0_iy1;
  logic [F-1:0]      s0_tx, s0_ty;
  // Stage 1: first hash multiply, squares for smoothstep.
  logic [31:0]       s1_a [2];
  logic [CELL_W-1:0] s1_iy, s1_iy1;
  logic [F-1:0]      s1_tx, s1_ty, s1_t2x, s1_t2y;
  // Stage 2: second hash multiply per corner, smoothstep weights.
  logic [31:0]       s2_a [2];
  logic [31:0]       s2_b [4];
  logic [F-1:0]      s2_tx, s2_ty;
  logic [F:0]        s2_sx, s2_sy;
  // Stage 3: table index per corner.
  logic [ANGLE_BITS-1:0] s3_idx [4];
  logic [F-1:0]      s3_tx, s3_ty;
  logic [F:0]        s3_sx, s3_sy;
  // Stage 4: gradients.
  logic [GRAD_W-1:0] s4_g [4];
  logic [F-1:0]      s4_tx, s4_ty;
  logic [F:0]        s4_sx, s4_sy;
  // Stage 5: gradient times offset.
  logic signed [PG_W-1:0] s5_px [4];
  logic signed [PG_W-1:0] s5_py [4];
  logic [F:0]        s5_sx, s5_sy;
  // Stage 6: dot products in Q24.
  logic signed [DOT_W-1:0] s6_d [4];
  logic [F:0]        s6_sx, s6_sy;
  // Stage 7: products of the y interpolation.
  logic signed [LP_W-1:0]  s7_p0, s7_p1;
  logic signed [DOT_W-1:0] s7_d00, s7_d10;
  logic [F:0]        s7_sx;
  // Stage 8: y interpolation results.
  logic signed [DOT_W-1:0] s8_ly, s8_ry;
  logic [F:0]        s8_sx;
  // Stage 9: product of the x interpolation.
  logic signed [LP_W-1:0]  s9_p;
  logic signed [DOT_W-1:0] s9_ly;
  // Stage 10: blended value in Q24.
  logic signed [DOT_W-1:0] s10_v;

  logic [F-1:0]      in_tx, in_ty;
  logic [CELL_W-1:0] in_ix, in_iy;
  logic signed [SUM_W-1:0] dsum [4];
  logic signed [DOT_W-1:0] dscaled [4];
  logic signed [DOT_W:0]   vround;
  logic signed [DOT_W-9:0] vq;

  assign {in_ix, in_iy, in_tx, in_ty} = item_data;

  // An item enters the pipeline only if the result queue has room reserved.
  assign item_take = item_valid && (reserved != RES_W'(OQ_DEPTH));
  assign res_pop   = pop && !empty;
  assign res_push  = vld[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      reserved <= '0;
    end else begin
      vld      <= {vld[PIPE_STAGES-2:0], item_take};
      reserved <= reserved + RES_W'(item_take) - RES_W'(res_pop);
    end
  end

  // Corner c is (c[0], c[1]) in (x, y); dx for the far corner is tx - 1.
  for (genvar c = 0; c < 4; c++) begin : g_corner
    logic signed [GRAD_C_W-1:0] gx, gy;
    logic signed [F:0]          dx, dy;
    logic [31:0]                iyc;
    logic [31:0]                hprod;

    assign gx  = s4_g[c][GRAD_W-1:GRAD_C_W];
    assign gy  = s4_g[c][GRAD_C_W-1:0];
    assign dx  = {1'(c % 2), s4_tx};
    assign dy  = {1'(c / 2), s4_ty};
    assign iyc = (c / 2 == 1) ? s1_iy1 : s1_iy;
    assign hprod = (s2_a[c % 2] ^ rot16(s2_b[c])) * HASH_MUL_C;
    assign dsum[c] = SUM_W'(s5_px[c]) + SUM_W'(s5_py[c]);

    if (F >= 9) begin : g_shr
      assign dscaled[c] = DOT_W'(dsum[c] >>> (F - 9));
    end else begin : g_shl
      assign dscaled[c] = DOT_W'(dsum[c]) <<< (9 - F);
    end

    always_ff @(posedge clk) begin
      s2_b[c]   <= (iyc ^ rot16(s1_a[c % 2])) * HASH_MUL_B;
      s3_idx[c] <= hprod[31 -: ANGLE_BITS];
      s4_g[c]   <= grad_rom[s3_idx[c]];
      s5_px[c]  <= gx * dx;
      s5_py[c]  <= gy * dy;
      s6_d[c]   <= dscaled[c];
    end
  end

  always_ff @(posedge clk) begin
    s0_ix  <= in_ix;
    s0_ix1 <= in_ix + 1'b1;
    s0_iy  <= in_iy;
    s0_iy1 <= in_iy + 1'b1;
    s0_tx  <= in_tx;
    s0_ty  <= in_ty;

    s1_a[0] <= s0_ix * HASH_MUL_A;
    s1_a[1] <= s0_ix1 * HASH_MUL_A;
    s1_iy   <= s0_iy;
    s1_iy1  <= s0_iy1;
    s1_tx   <= s0_tx;
    s1_ty   <= s0_ty;
    s1_t2x  <= F'((2*F)'(s0_tx * s0_tx) >> F);
    s1_t2y  <= F'((2*F)'(s0_ty * s0_ty) >> F);

    s2_a   <= s1_a;
    s2_tx  <= s1_tx;
    s2_ty  <= s1_ty;
    s2_sx  <= (F+1)'((2*F+2)'(s1_t2x * (THREE - {1'b0, s1_tx, 1'b0})) >> F);
    s2_sy  <= (F+1)'((2*F+2)'(s1_t2y * (THREE - {1'b0, s1_ty, 1'b0})) >> F);

    s3_tx <= s2_tx;
    s3_ty <= s2_ty;
    s3_sx <= s2_sx;
    s3_sy <= s2_sy;

    s4_tx <= s3_tx;
    s4_ty <= s3_ty;
    s4_sx <= s3_sx;
    s4_sy <= s3_sy;

    s5_sx <= s4_sx;
    s5_sy <= s4_sy;

    s6_sx <= s5_sx;
    s6_sy <= s5_sy;

    s7_p0  <= DIFF_W'(DIFF_W'(s6_d[2]) - DIFF_W'(s6_d[0])) * $signed({1'b0, s6_sy});
    s7_p1  <= DIFF_W'(DIFF_W'(s6_d[3]) - DIFF_W'(s6_d[1])) * $signed({1'b0, s6_sy});
    s7_d00 <= s6_d[0];
    s7_d10 <= s6_d[1];
    s7_sx  <= s6_sx;

    s8_ly <= s7_d00 + DOT_W'(s7_p0 >>> F);
    s8_ry <= s7_d10 + DOT_W'(s7_p1 >>> F);
    s8_sx <= s7_sx;

    s9_p  <= DIFF_W'(DIFF_W'(s8_ry) - DIFF_W'(s8_ly)) * $signed({1'b0, s8_sx});
    s9_ly <= s8_ly;

    s10_v <= s9_ly + DOT_W'(s9_p >>> F);
  end

  // Round half up from Q24 to Q15, then saturate.
  assign vround = (DOT_W+1)'(s10_v) + (DOT_W+1)'(256);
  assign vq     = (DOT_W-8)'(vround >>> 9);

  always_comb begin
    if (vq > (DOT_W-8)'(32767)) begin
      res_value = 16'sh7FFF;
    end else if (vq < -(DOT_W-8)'(32768)) begin
      res_value = 16'sh8000;
    end else begin
      res_value = NOISE_W'(vq);
    end
  end

  gnd_fifo #(
    .WIDTH(NOISE_W),
    .DEPTH(OQ_DEPTH)
  ) u_result_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res_value),
    .rd_en  (pop),
    .rd_data(noise_value),
    .full   (oq_full),
    .empty  (empty)
  );

  // The credit count keeps the result queue from overflowing; full is only
  // observed to keep the queue interface complete.
  logic unused_full;
  assign unused_full = oq_full;

endmodule

[rtl/gradient_noise_2d.sv]
// ----------------------------------------------------------------------------
// gradient_noise_2d
// 2D gradient noise: one signed fixed-point point in, one Q1.15 value out.
// ----------------------------------------------------------------------------
// Throughput: one point per cycle while the result queue has free slots, set by
// the fully pipelined datapath fed from a four-entry input queue and drained
// through a 16-entry result queue; with all its slots reserved, points wait.
// Reset clears the queues, valid bits and credit count, not the pipeline data.
module gradient_noise_2d #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned ANGLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] noise_value
);
  import gnd_pkg::*;

  localparam int unsigned ITEM_W = 2 * CELL_W + 2 * FRAC_BITS;

  logic              item_valid;
  logic              item_take;
  logic [ITEM_W-1:0] item_data;

  gnd_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .item_valid(item_valid),
    .item_take (item_take),
    .item_data (item_data)
  );

  gnd_back #(
    .FRAC_BITS (FRAC_BITS),
    .ANGLE_BITS(ANGLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item_data  (item_data),
    .empty      (empty),
    .pop        (pop),
    .noise_value(noise_value)
  );

endmodule

[dv/gradient_noise_2d_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_2d_checker
// Watches the point and noise channels of the gradient noise block, computes
// the expected noise value for every accepted point and compares it with the
// value popped from the block, in order.
// ----------------------------------------------------------------------------
module gradient_noise_2d_checker #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned ANGLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [15:0] noise_value,
  output int                 fail_count,
  output int                 pending
);

  logic signed [15:0] noise_q[$];

  assign pending = noise_q.size();

  function automatic logic [31:0] hash_corner(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] a;
    logic [31:0] b;
    a = cx * gnd_pkg::HASH_MUL_A;
    b = cy ^ {a[15:0], a[31:16]};
    b = b * gnd_pkg::HASH_MUL_B;
    a = a ^ {b[15:0], b[31:16]};
    a = a * gnd_pkg::HASH_MUL_C;
    return a;
  endfunction

  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  function automatic logic [63:0] one_less(logic [63:0] v);
    return (v < (64'd1 << 30)) ? ((64'd1 << 30) - v) : 64'd0;
  endfunction

  function automatic longint round_q15(logic [63:0] v);
    logic [63:0] r;
    r = (v + 64'd16384) >> 15;
    return (r > 64'd32768) ? 32768 : longint'(r);
  endfunction

  // Unit gradient from the top bits of the angle word, via Taylor series.
  function automatic void corner_gradient(logic [31:0] w, output longint gx,
                                          output longint gy);
    logic [31:0] phase;
    logic [63:0] th, t2, hs, hc;
    longint s;
    longint c;
    phase = (w >> (32 - ANGLE_BITS)) << (32 - ANGLE_BITS);
    th = fx_mul({34'd0, phase[29:0]}, gnd_pkg::PI_HALF_Q30);
    t2 = fx_mul(th, th);
    hs = one_less(t2 / 110);
    hs = one_less(fx_mul(t2, hs) / 72);
    hs = one_less(fx_mul(t2, hs) / 42);
    hs = one_less(fx_mul(t2, hs) / 20);
    hs = one_less(fx_mul(t2, hs) / 6);
    hs = fx_mul(th, hs);
    hc = one_less(t2 / 132);
    hc = one_less(fx_mul(t2, hc) / 90);
    hc = one_less(fx_mul(t2, hc) / 56);
    hc = one_less(fx_mul(t2, hc) / 30);
    hc = one_less(fx_mul(t2, hc) / 12);
    hc = one_less(fx_mul(t2, hc) / 2);
    s = round_q15(hs);
    c = round_q15(hc);
    case (phase[31:30])
      gnd_pkg::QUAD_0: begin gx = c;  gy = s;  end
      gnd_pkg::QUAD_1: begin gx = -s; gy = c;  end
      gnd_pkg::QUAD_2: begin gx = -c; gy = -s; end
      default:         begin gx = s;  gy = -c; end
    endcase
  endfunction

  // The >>> on longint is a floor division by a power of two.
  function automatic longint corner_dot(logic [31:0] cx, logic [31:0] cy,
                                        longint dx, longint dy);
    longint gx;
    longint gy;
    longint d;
    int sh;
    corner_gradient(hash_corner(cx, cy), gx, gy);
    d = gx * dx + gy * dy;
    sh = 15 + FRAC_BITS - 24;
    if (sh >= 0) return d >>> sh;
    return d <<< (-sh);
  endfunction

  function automatic longint blend(longint a, longint b, longint s);
    return a + (((b - a) * s) >>> FRAC_BITS);
  endfunction

  function automatic longint fade(longint t);
    longint one;
    one = longint'(1) << FRAC_BITS;
    return ((((t * t) >>> FRAC_BITS)) * (3 * one - 2 * t)) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [15:0] predict_noise(logic signed [31:0] px,
                                                       logic signed [31:0] py);
    logic [31:0] ix, iy, ix1, iy1;
    longint one, tx, ty, sx, sy, ly, ry, v;
    ix = px >>> FRAC_BITS;
    iy = py >>> FRAC_BITS;
    ix1 = ix + 32'd1;
    iy1 = iy + 32'd1;
    one = longint'(1) << FRAC_BITS;
    tx = longint'(px) & (one - 1);
    ty = longint'(py) & (one - 1);
    sx = fade(tx);
    sy = fade(ty);
    ly = blend(corner_dot(ix, iy, tx, ty), corner_dot(ix, iy1, tx, ty - one), sy);
    ry = blend(corner_dot(ix1, iy, tx - one, ty),
               corner_dot(ix1, iy1, tx - one, ty - one), sy);
    v = blend(ly, ry, sx);
    v = (v + 256) >>> 9;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst) begin
      if (push && !full) noise_q.push_back(predict_noise(x_coord, y_coord));
      if (pop && !empty) begin
        if (noise_q.size() == 0) begin
          $error("noise_value: unexpected transaction, actual %0d", noise_value);
          fail_count <= fail_count + 1;
        end else begin
          want = noise_q.pop_front();
          if (noise_value !== want) begin
            $error("noise_value: expected %0d, actual %0d", want, noise_value);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[dv/tb_gradient_noise_2d.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_noise_2d
// Drives directed and random points into the gradient noise block with random
// gaps on both sides and one long output stall; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_gradient_noise_2d;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic signed [31:0] x_coord = '0;
  logic signed [31:0] y_coord = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [15:0] noise_value;
  int                 fail_count;
  int                 pending;
  bit                 quiet_phase = 1'b0;
  bit                 hold_sink = 1'b0;

  always #5 clk = ~clk;

  gradient_noise_2d i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .x_coord(x_coord),
    .y_coord(y_coord), .empty(empty), .pop(pop), .noise_value(noise_value)
  );

  gradient_noise_2d_checker i_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .x_coord(x_coord),
    .y_coord(y_coord), .empty(empty), .pop(pop), .noise_value(noise_value),
    .fail_count(fail_count), .pending(pending)
  );

  // Offers one point, with an optional gap first, and holds it until accepted.
  task automatic send_point(logic [31:0] px, logic [31:0] py);
    while (!quiet_phase && $urandom_range(99) < 12) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    x_coord <= px;
    y_coord <= py;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic logic [31:0] near_cell();
    logic [31:0] v;
    v = {16'($urandom_range(65535)), 16'h0} + 32'($urandom_range(511));
    case ($urandom_range(3))
      0: return $urandom();
      1: return v;
      2: return v - 32'd256;
      default: return {($urandom_range(1) ? 16'h8000 : 16'h7fff), 16'($urandom())};
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst || hold_sink) pop <= 1'b0;
    else pop <= quiet_phase || ($urandom_range(99) >= 12);
  end

  initial begin
    logic [31:0] corners[8];
    int wait_cycles;
    corners = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                32'h0000_8000, 32'h0000_ffff, 32'h0001_0000, 32'hffff_0000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (corners[i]) begin
      send_point(corners[i], corners[(i * 3 + 1) % 8]);
      send_point(corners[i], corners[i]);
    end
    // Fill the block while the output side is stalled.
    hold_sink <= 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        hold_sink <= 1'b0;
      end
      for (int n = 0; n < 40; n++) send_point($urandom(), $urandom());
    join
    for (int n = 0; n < 410; n++) begin
      if (n == 150) quiet_phase <= 1'b1;
      if (n == 250) quiet_phase <= 1'b0;
      send_point(near_cell(), near_cell());
    end
    push <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
rtl/gnd_pkg.sv
rtl/gnd_fifo.sv
rtl/gnd_front.sv
rtl/gnd_back.sv
rtl/gradient_noise_2d.sv
dv/gradient_noise_2d_checker.sv
dv/tb_gradient_noise_2d.sv
